### rtl/vliw_dsp_opcode_class_decoder_core_assert.svh
// Assertion macros for the instruction format decoder.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef VLIW_DSP_OPCODE_CLASS_DECODER_CORE_ASSERT_SVH
`define VLIW_DSP_OPCODE_CLASS_DECODER_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define VDOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define VDOC_ASSERT_IMPLY(label, ante, cons, msg) \
    `VDOC_ASSERT(label, (ante) |-> (cons), msg)

`endif

### rtl/vdoc_pkg.sv
// Shared types, codes and helpers for the instruction format decoder.
// Used by vdoc_feature, vdoc_class_sel and the top level; no dependencies.
package vdoc_pkg;

    // Encoding class codes, numbered in decision-tree order
    localparam logic [4:0] CLS_UNDEF       = 5'd0;
    localparam logic [4:0] CLS_S_ADDKPC    = 5'd1;
    localparam logic [4:0] CLS_S_BREG      = 5'd2;
    localparam logic [4:0] CLS_S_BNOP_REG  = 5'd3;
    localparam logic [4:0] CLS_S_BDEC      = 5'd4;
    localparam logic [4:0] CLS_S_BNOP_DISP = 5'd5;
    localparam logic [4:0] CLS_S_UNARY     = 5'd6;
    localparam logic [4:0] CLS_S_BPTR      = 5'd7;
    localparam logic [4:0] CLS_S_SRC       = 5'd8;
    localparam logic [4:0] CLS_N_NOP       = 5'd9;
    localparam logic [4:0] CLS_L_UNARY     = 5'd10;
    localparam logic [4:0] CLS_L_SRC_UNC   = 5'd11;
    localparam logic [4:0] CLS_L_SRC       = 5'd12;
    localparam logic [4:0] CLS_M_MPY       = 5'd13;
    localparam logic [4:0] CLS_D_LKWD      = 5'd14;
    localparam logic [4:0] CLS_D_SRC       = 5'd15;
    localparam logic [4:0] CLS_D_ADDAX     = 5'd16;
    localparam logic [4:0] CLS_D_LDST_LONG = 5'd17;
    localparam logic [4:0] CLS_D_LDST      = 5'd18;
    localparam logic [4:0] CLS_MX_UNARY    = 5'd19;
    localparam logic [4:0] CLS_MX_SRC_UNC  = 5'd20;
    localparam logic [4:0] CLS_MX_COMPOUND = 5'd21;
    localparam logic [4:0] CLS_SX_SRC_UNC  = 5'd22;
    localparam logic [4:0] CLS_SX_SRC      = 5'd23;
    localparam logic [4:0] CLS_DX_SRC      = 5'd24;
    localparam logic [4:0] CLS_S_FIELD     = 5'd25;
    localparam logic [4:0] CLS_S_MVK       = 5'd26;
    localparam logic [4:0] CLS_S_ADDK      = 5'd27;
    localparam logic [4:0] CLS_S_CALL      = 5'd28;
    localparam logic [4:0] CLS_S_BDISP     = 5'd29;

    // Execution unit codes
    localparam logic [3:0] UNIT_NIL  = 4'd0;
    localparam logic [3:0] UNIT_L1   = 4'd1;
    localparam logic [3:0] UNIT_L2   = 4'd2;
    localparam logic [3:0] UNIT_S1   = 4'd3;
    localparam logic [3:0] UNIT_S2   = 4'd4;
    localparam logic [3:0] UNIT_M1   = 4'd5;
    localparam logic [3:0] UNIT_M2   = 4'd6;
    localparam logic [3:0] UNIT_D1   = 4'd7;
    localparam logic [3:0] UNIT_D2   = 4'd8;

    // Field match flags produced from one instruction word
    typedef struct packed {
        logic grp_s;       // bits 5..2 select the S opcode group
        logic s_addkpc;
        logic s_breg;
        logic t_zero;      // bits 27..23 all zero
        logic t_one;       // bits 27..23 equal one
        logic s_bdec;
        logic s_bnop;
        logic s_unary;
        logic s_bptr;
        logic nop;
        logic grp_l;
        logic l_unary;
        logic creg_unc;    // condition field marks an unconditional word
        logic grp_m;
        logic grp_d;
        logic d_lkwd;
        logic ls_long;
        logic ls_basic;
        logic grp_x;
        logic x_sel_lo;
        logic x_sel_s;
        logic mx_unary;
        logic s_field;
        logic s_mvk;
        logic s_addk;
        logic s_disp;
    } vdoc_flags_t;

    // Map a class to its execution unit
    function automatic logic [3:0] unit_of(input logic [4:0] cls, input logic side,
                                           input logic bit7);
        logic [3:0] unit;
        unit = UNIT_NIL;
        unique case (cls)
            CLS_S_ADDKPC, CLS_S_BREG, CLS_S_BNOP_REG, CLS_S_BDEC, CLS_S_BNOP_DISP,
            CLS_S_UNARY, CLS_S_BPTR, CLS_S_SRC, CLS_SX_SRC_UNC, CLS_SX_SRC,
            CLS_S_FIELD, CLS_S_MVK, CLS_S_ADDK, CLS_S_CALL, CLS_S_BDISP:
                unit = side ? UNIT_S2 : UNIT_S1;
            CLS_L_UNARY, CLS_L_SRC_UNC, CLS_L_SRC:
                unit = side ? UNIT_L2 : UNIT_L1;
            CLS_M_MPY, CLS_MX_UNARY, CLS_MX_SRC_UNC, CLS_MX_COMPOUND:
                unit = side ? UNIT_M2 : UNIT_M1;
            CLS_D_LKWD, CLS_D_SRC, CLS_D_ADDAX, CLS_DX_SRC:
                unit = side ? UNIT_D2 : UNIT_D1;
            CLS_D_LDST_LONG:
                unit = UNIT_D2;
            CLS_D_LDST:
                unit = bit7 ? UNIT_D2 : UNIT_D1;
            default:
                unit = UNIT_NIL;
        endcase
        return unit;
    endfunction

endpackage

### rtl/vdoc_feature.sv
// Field matcher: compares the bit fields of one instruction word.
// Depends on vdoc_pkg for the flag struct.
module vdoc_feature (
    input  logic [31:0]          word,
    output vdoc_pkg::vdoc_flags_t flags
);

    logic [5:0] op;
    logic       xbit;
    logic       sbit;
    logic [4:0] b2_6;
    logic [3:0] creg_z;
    logic [1:0] sel;

    assign op     = word[11:6];
    assign xbit   = word[12];
    assign sbit   = word[1];
    assign b2_6   = word[6:2];
    assign creg_z = word[31:28];
    assign sel    = word[11:10];

    // Match every field the decision tree tests
    always_comb
    begin
        flags.grp_s    = (word[5:2] == 4'h8);
        flags.s_addkpc = !xbit && (op == 6'h05);
        flags.s_breg   = (op == 6'h0D);
        flags.t_zero   = (word[27:23] == 5'd0);
        flags.t_one    = (word[27:23] == 5'd1);
        flags.s_bdec   = (op == 6'h00);
        flags.s_bnop   = !xbit && (op == 6'h04);
        flags.s_unary  = (op == 6'h3A);
        flags.s_bptr   = (word[27:21] == 7'd0) && (word[17:6] == 12'h003) && sbit;
        flags.nop      = (word[12:1] == 12'd0) && (word[31:17] == 15'd0);
        flags.grp_l    = (b2_6[2:0] == 3'h6);
        flags.l_unary  = (word[11:5] == 7'h1A);
        flags.creg_unc = (creg_z == 4'h1);
        flags.grp_m    = (b2_6 == 5'h00);
        flags.grp_d    = (b2_6 == 5'h10);
        flags.d_lkwd   = sbit && (word[17:10] == 8'h01);
        flags.ls_long  = (word[3:2] == 2'h3);
        flags.ls_basic = (word[3:2] == 2'h1);
        flags.grp_x    = (word[5:2] == 4'hC);
        flags.x_sel_lo = !sel[1];
        flags.x_sel_s  = (sel == 2'h3);
        flags.mx_unary = (word[10:6] == 5'h03);
        flags.s_field  = (word[5:2] == 4'h2);
        flags.s_mvk    = (word[5:2] == 4'hA);
        flags.s_addk   = (b2_6 == 5'h14);
        flags.s_disp   = (b2_6 == 5'h04);
    end

endmodule

### rtl/vdoc_class_sel.sv
// Class selector: walks the decision tree over precomputed field flags.
// Depends on vdoc_pkg for the flag struct and class codes.
module vdoc_class_sel (
    input  vdoc_pkg::vdoc_flags_t flags,
    output logic [4:0]            cls
);

    // Pick the first matching branch of the tree
    always_comb
    begin
        priority if (flags.grp_s)
        begin
            priority if (flags.s_addkpc)  cls = vdoc_pkg::CLS_S_ADDKPC;
            else if (flags.s_breg)
            begin
                priority if (flags.t_zero)     cls = vdoc_pkg::CLS_S_BREG;
                else if (flags.t_one)          cls = vdoc_pkg::CLS_S_BNOP_REG;
                else                           cls = vdoc_pkg::CLS_UNDEF;
            end
            else if (flags.s_bdec)        cls = vdoc_pkg::CLS_S_BDEC;
            else if (flags.s_bnop)        cls = vdoc_pkg::CLS_S_BNOP_DISP;
            else if (flags.s_unary)       cls = vdoc_pkg::CLS_S_UNARY;
            else if (flags.s_bptr)        cls = vdoc_pkg::CLS_S_BPTR;
            else                          cls = vdoc_pkg::CLS_S_SRC;
        end
        else if (flags.nop)               cls = vdoc_pkg::CLS_N_NOP;
        else if (flags.grp_l)
        begin
            priority if (flags.l_unary)   cls = vdoc_pkg::CLS_L_UNARY;
            else if (flags.creg_unc)      cls = vdoc_pkg::CLS_L_SRC_UNC;
            else                          cls = vdoc_pkg::CLS_L_SRC;
        end
        else if (flags.grp_m)             cls = vdoc_pkg::CLS_M_MPY;
        else if (flags.grp_d)
            cls = flags.d_lkwd ? vdoc_pkg::CLS_D_LKWD : vdoc_pkg::CLS_D_SRC;
        else if (flags.ls_long)
            cls = flags.creg_unc ? vdoc_pkg::CLS_D_ADDAX : vdoc_pkg::CLS_D_LDST_LONG;
        else if (flags.ls_basic)          cls = vdoc_pkg::CLS_D_LDST;
        else if (flags.grp_x)
        begin
            priority if (flags.x_sel_lo)
            begin
                priority if (flags.mx_unary)   cls = vdoc_pkg::CLS_MX_UNARY;
                else if (flags.creg_unc)       cls = vdoc_pkg::CLS_MX_SRC_UNC;
                else                           cls = vdoc_pkg::CLS_MX_COMPOUND;
            end
            else if (flags.x_sel_s)
                cls = flags.creg_unc ? vdoc_pkg::CLS_SX_SRC_UNC : vdoc_pkg::CLS_SX_SRC;
            else                          cls = vdoc_pkg::CLS_DX_SRC;
        end
        else if (flags.s_field)           cls = vdoc_pkg::CLS_S_FIELD;
        else if (flags.s_mvk)             cls = vdoc_pkg::CLS_S_MVK;
        else if (flags.s_addk)            cls = vdoc_pkg::CLS_S_ADDK;
        else if (flags.s_disp)
            cls = flags.creg_unc ? vdoc_pkg::CLS_S_CALL : vdoc_pkg::CLS_S_BDISP;
        else                              cls = vdoc_pkg::CLS_UNDEF;
    end

endmodule

### rtl/vliw_dsp_opcode_class_decoder_core.sv
// Top level of the instruction format decoder: four-stage pipeline.
// Depends on vdoc_pkg, vdoc_feature, vdoc_class_sel and the assertion header.

// Classifies one 32-bit instruction word per clock, unless out_stall holds
// the pipeline, into its encoding class (0 undefined, 1..29), its execution
// unit and the parallel bit. Throughput is one word per cycle while the
// output is not stalled. A word passes through four register stages: input
// capture, field match, class selection and unit lookup with the output
// register. Each stage has its own valid bit and loads whenever it is empty
// or the stage after it moves, so bubbles close up behind a stalled output
// and the input keeps taking words until the pipeline is full.
`include "vliw_dsp_opcode_class_decoder_core_assert.svh"

module vliw_dsp_opcode_class_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instr_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  format_class,
    output logic [3:0]  exec_unit,
    output logic        parallel_flag
);

    // Stage 1: captured word
    logic                  v1_reg;
    logic [31:0]           word1_reg;

    // Stage 2: field flags
    logic                  v2_reg;
    vdoc_pkg::vdoc_flags_t flags2_reg;
    vdoc_pkg::vdoc_flags_t flags2_next;
    logic                  side2_reg;
    logic                  bit7_2_reg;
    logic                  par2_reg;

    // Stage 3: class
    logic                  v3_reg;
    logic [4:0]            cls3_reg;
    logic [4:0]            cls3_next;
    logic                  side3_reg;
    logic                  bit7_3_reg;
    logic                  par3_reg;

    // Stage 4: output
    logic                  out_valid_reg;
    logic [4:0]            class_out_reg;
    logic [3:0]            unit_out_reg;
    logic [3:0]            unit_out_next;
    logic                  par_out_reg;

    logic                  en_out;
    logic                  en3;
    logic                  en2;
    logic                  en1;

    // Advance each stage when it is empty or its successor moves
    assign en_out   = !out_valid_reg || !out_stall;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    // Match fields of the captured word
    vdoc_feature u_feature (
        .word  (word1_reg),
        .flags (flags2_next)
    );

    // Walk the decision tree
    vdoc_class_sel u_class_sel (
        .flags (flags2_reg),
        .cls   (cls3_next)
    );

    assign unit_out_next = vdoc_pkg::unit_of(cls3_reg, side3_reg, bit7_3_reg);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en_out)
                out_valid_reg <= v3_reg;
        end
    end

    // Payload registers, held while their stage is stalled
    always_ff @(posedge clk)
    begin
        if (en1)
            word1_reg <= instr_word;
        if (en2)
        begin
            flags2_reg <= flags2_next;
            side2_reg  <= word1_reg[1];
            bit7_2_reg <= word1_reg[7];
            par2_reg   <= word1_reg[0];
        end
        if (en3)
        begin
            cls3_reg   <= cls3_next;
            side3_reg  <= side2_reg;
            bit7_3_reg <= bit7_2_reg;
            par3_reg   <= par2_reg;
        end
        if (en_out)
        begin
            class_out_reg <= cls3_reg;
            unit_out_reg  <= unit_out_next;
            par_out_reg   <= par3_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign format_class  = class_out_reg;
    assign exec_unit     = unit_out_reg;
    assign parallel_flag = par_out_reg;

    // Checks
    `VDOC_ASSERT_IMPLY(a_stall_full, in_stall, v1_reg && v2_reg && v3_reg && out_valid_reg,
                       "input stalled while the pipeline has a free stage")
    `VDOC_ASSERT_IMPLY(a_class_range, out_valid_reg, class_out_reg <= vdoc_pkg::CLS_S_BDISP,
                       "class code out of range")
    `VDOC_ASSERT_IMPLY(a_no_unit, out_valid_reg && (class_out_reg == vdoc_pkg::CLS_UNDEF ||
                       class_out_reg == vdoc_pkg::CLS_N_NOP), unit_out_reg == vdoc_pkg::UNIT_NIL,
                       "undefined or nop word assigned a unit")
    `VDOC_ASSERT_IMPLY(a_unit_set, out_valid_reg && class_out_reg != vdoc_pkg::CLS_UNDEF &&
                       class_out_reg != vdoc_pkg::CLS_N_NOP, unit_out_reg != vdoc_pkg::UNIT_NIL,
                       "defined class without a unit")

endmodule
